FILE: hw/rtl/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

  localparam int BPI = 8;
  localparam int MAX_READ = 32 * BPI;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic load;
    logic apply;
    logic wr_step;
    logic rd_step;
    logic put_data;
    logic put_final;
  } cmd_t;

  typedef struct packed {
    logic go_write;
    logic go_read;
    logic rem_one;
    logic rem_zero;
    logic chunk_full;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/byte_ring_fifo.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// in        in   in_valid/in_stall    operation data_bytes length dest_room
// out       out  out_valid/out_stall  status out_bytes byte_count last used_count free_count
// cfg       in   cfg_we               cfg_data (capacity)
//
// one word at a time; a command is loaded, decided and answered, and a write also stores one byte per step
// a read or peek sets the ram address and then takes the data for each byte, and puts each result word: one ram port,
// one byte per access with a registered read
// rst is synchronous; a capacity write also empties the ring
// the next word is taken while the last result still waits in the output register

module byte_ring_fifo #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [63:0] data_bytes,
  input  logic [8:0]  length,
  input  logic [8:0]  dest_room,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last,
  output logic [8:0]  used_count,
  output logic [8:0]  free_count
);

  import brf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;

  assign in_stall = rst || !idle;

  brf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .sts     (sts),
    .cmd     (cmd),
    .idle    (idle)
  );

  brf_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .operation (operation),
    .data_bytes(data_bytes),
    .length    (length),
    .dest_room (dest_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_bytes (out_bytes),
    .byte_count(byte_count),
    .last      (last),
    .used_count(used_count),
    .free_count(free_count)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while busy");

  a_partial_is_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (status == 1'b0 && byte_count == 4'(BPI)))
    else $error("non-final result not a full data word");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count == 4'd0) |-> (out_bytes == 64'd0 && last))
    else $error("result without data carries bytes");

  a_counts_fit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(used_count) + 32'(free_count) <= DEPTH))
    else $error("fill and free exceed the store");

  a_single_put: assert property (@(posedge clk) disable iff (rst)
    !(cmd.put_data && cmd.put_final))
    else $error("two results loaded at once");

endmodule

FILE: hw/rtl/brf_ram.sv
`timescale 1ns / 1ps

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/brf_ctrl.sv
`timescale 1ns / 1ps

module brf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  brf_pkg::sts_t sts,
  output brf_pkg::cmd_t cmd,
  output logic          idle
);

  import brf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_RADDR  = 3'd3;
  localparam logic [2:0] S_RDATA  = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.apply = 1'b1;
        if (sts.go_write) begin
          state_next = S_WRITE;
        end else if (sts.go_read) begin
          state_next = S_RADDR;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.rem_one) begin
          state_next = S_FINAL;
        end
      end
      S_RADDR: begin
        state_next = S_RDATA;
      end
      S_RDATA: begin
        cmd.rd_step = 1'b1;
        if (sts.chunk_full || sts.rem_one) begin
          state_next = S_PUT;
        end else begin
          state_next = S_RADDR;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.put_data = 1'b1;
          state_next   = sts.rem_zero ? S_IDLE : S_RADDR;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.put_final = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

endmodule

FILE: hw/rtl/brf_dp.sv
`timescale 1ns / 1ps

module brf_dp #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  brf_pkg::cmd_t cmd,
  output brf_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_data,
  input  logic [2:0]    operation,
  input  logic [63:0]   data_bytes,
  input  logic [8:0]    length,
  input  logic [8:0]    dest_room,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          status,
  output logic [63:0]   out_bytes,
  output logic [3:0]    byte_count,
  output logic          last,
  output logic [8:0]    used_count,
  output logic [8:0]    free_count
);

  import brf_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [8:0]    cap_reg;
  logic [CW-1:0] cap_eff;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] fill;

  logic [2:0]  op;
  logic [63:0] data;
  logic [8:0]  len;
  logic [8:0]  room;
  logic [8:0]  rem;
  logic        refuse_r;
  logic [63:0] word;
  logic [3:0]  nbytes;

  logic          refuse;
  logic [SW-1:0] head_sum;
  logic [IW-1:0] head_adv;
  logic [7:0]    rdata;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(1);
    wrap_inc = (s == SW'(c)) ? '0 : IW'(s);
  endfunction

  always_comb begin
    if (cap_reg == 9'd0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_reg) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_reg);
    end
  end

  always_comb begin
    case (op)
      OP_WRITE:  refuse = (32'(len) > BPI) || (32'(len) > 32'(cap_eff - fill));
      OP_READ,
      OP_PEEK:   refuse = (32'(len) > 32'(fill)) || (room < len) || (32'(len) > MAX_READ);
      OP_REMOVE,
      OP_CLEAR:  refuse = 1'b0;
      default:   refuse = 1'b1;
    endcase
  end

  // len never exceeds the fill here, so one subtract brings it back in range
  assign head_sum = SW'(head) + SW'(len);
  assign head_adv = (head_sum >= SW'(cap_eff)) ? IW'(head_sum - SW'(cap_eff)) : IW'(head_sum);

  assign sts.go_write   = !refuse && (op == OP_WRITE) && (len != 9'd0);
  assign sts.go_read    = !refuse && ((op == OP_READ) || (op == OP_PEEK)) && (len != 9'd0);
  assign sts.rem_one    = (rem == 9'd1);
  assign sts.rem_zero   = (rem == 9'd0);
  assign sts.chunk_full = (nbytes == 4'(BPI - 1));
  assign sts.out_free   = !out_valid || !out_stall;

  brf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_step),
    .waddr(tail),
    .wdata(data[7:0]),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  // ring pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= 9'd256;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
    end else if (cfg_we) begin
      cap_reg <= cfg_data;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
    end else if (cmd.apply && !refuse) begin
      case (op)
        OP_READ: begin
          head <= head_adv;
          fill <= fill - CW'(len);
        end
        OP_REMOVE: begin
          if (32'(len) > 32'(fill)) begin
            head <= '0;
            tail <= '0;
            fill <= '0;
          end else begin
            head <= head_adv;
            fill <= fill - CW'(len);
          end
        end
        OP_CLEAR: begin
          head <= '0;
          tail <= '0;
          fill <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.wr_step) begin
      tail <= wrap_inc(tail, cap_eff);
      fill <= fill + CW'(1);
    end
  end

  // working registers of the current word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= operation;
      data <= data_bytes;
      len  <= length;
      room <= dest_room;
    end
    if (cmd.apply) begin
      refuse_r <= refuse;
      rem      <= len;
      rd_idx   <= head;
      word     <= '0;
      nbytes   <= '0;
    end
    if (cmd.wr_step) begin
      data <= data >> 8;
      rem  <= rem - 9'd1;
    end
    if (cmd.rd_step) begin
      word[{nbytes[2:0], 3'b000} +: 8] <= rdata;
      nbytes <= nbytes + 4'd1;
      rem    <= rem - 9'd1;
      rd_idx <= wrap_inc(rd_idx, cap_eff);
    end
    if (cmd.put_data) begin
      word   <= '0;
      nbytes <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_data || cmd.put_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_data) begin
      status     <= 1'b0;
      out_bytes  <= word;
      byte_count <= nbytes;
      last       <= (rem == 9'd0);
      used_count <= 9'(fill);
      free_count <= 9'(cap_eff - fill);
    end else if (cmd.put_final) begin
      status     <= refuse_r;
      out_bytes  <= '0;
      byte_count <= '0;
      last       <= 1'b1;
      used_count <= 9'(fill);
      free_count <= 9'(cap_eff - fill);
    end
  end

endmodule
